// ===== design/tlbpt_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlbpt_pkg
// Shared widths, parameter defaults and control types of the TLB page table
// translator.
// ----------------------------------------------------------------------------
package tlbpt_pkg;

   // fixed field widths
   localparam int ADDR_WIDTH     = 16;
   localparam int PHYS_WIDTH     = 15;
   localparam int TOTAL_WIDTH    = 32;
   localparam int RSP_DATA_WIDTH = 80;
   localparam int RSP_USER_WIDTH = 2;

   // parameter defaults
   localparam int TLB_ENTRIES_DEF  = 16;
   localparam int PAGE_COUNT_DEF   = 256;
   localparam int FRAME_COUNT_DEF  = 128;
   localparam int OFFSET_WIDTH_DEF = 8;

   // reciprocal scaling for the page wrap when the page count is no power of two
   localparam int RECIP_SHIFT = 24;

   // update commands from the sequencer to the TLB
   typedef struct packed {
      logic fill;
      logic evict;
   } tlb_ctl_type;

endpackage

// ===== design/tlbpt_tlb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlbpt_tlb
// Fully associative TLB in flip-flops: parallel lookup with lowest-index
// priority, invalidation of an evicted page and round-robin fill.
// ----------------------------------------------------------------------------
module tlbpt_tlb
   import tlbpt_pkg::*;
#(
   parameter int TLB_ENTRIES = TLB_ENTRIES_DEF,
   parameter int PW          = 8,
   parameter int FW          = 7
) (
   input  logic          clock,
   input  logic          reset,
   input  logic [PW-1:0] lookup_page,
   input  tlb_ctl_type   ctl,
   input  logic [FW-1:0] fill_frame,
   input  logic [PW-1:0] evict_page,
   output logic          hit,
   output logic [FW-1:0] hit_frame
);

   localparam int TW = $clog2(TLB_ENTRIES);

   logic [TLB_ENTRIES-1:0] valid_ff;
   logic [TLB_ENTRIES-1:0] valid_in;
   logic [PW-1:0]          page_ff  [TLB_ENTRIES];
   logic [FW-1:0]          frame_ff [TLB_ENTRIES];
   logic [TW-1:0]          fill_ptr_ff;
   logic [TW-1:0]          fill_ptr_in;

   // match every entry, lowest index wins
   always_comb begin
      hit       = 1'b0;
      hit_frame = '0;
      for (int i = TLB_ENTRIES - 1; i >= 0; i--) begin
         if (valid_ff[i] && page_ff[i] == lookup_page) begin
            hit       = 1'b1;
            hit_frame = frame_ff[i];
         end
      end
   end

   // advance the round-robin pointer, wrap at the last entry
   always_comb begin
      fill_ptr_in = fill_ptr_ff;
      if (ctl.fill) begin
         if (32'(fill_ptr_ff) == TLB_ENTRIES - 1) begin
            fill_ptr_in = '0;
         end else begin
            fill_ptr_in = fill_ptr_ff + 1'b1;
         end
      end
   end

   // drop entries of the evicted page, then mark the filled entry valid
   always_comb begin
      valid_in = valid_ff;
      for (int i = 0; i < TLB_ENTRIES; i++) begin
         if (ctl.evict && valid_ff[i] && page_ff[i] == evict_page) begin
            valid_in[i] = 1'b0;
         end
      end
      if (ctl.fill) begin
         valid_in[fill_ptr_ff] = 1'b1;
      end
   end

   // hold valid bits and the fill pointer
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         fill_ptr_ff <= '0;
      end else begin
         valid_ff    <= valid_in;
         fill_ptr_ff <= fill_ptr_in;
      end
   end

   // hold page and frame of the filled entry
   always_ff @(posedge clock) begin
      if (ctl.fill) begin
         page_ff[fill_ptr_ff]  <= lookup_page;
         frame_ff[fill_ptr_ff] <= fill_frame;
      end
   end

endmodule

// ===== design/tlb_page_table_translator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlb_page_table_translator
// Translates logical addresses through a TLB and a page map held in memory,
// assigning frames in FIFO order on a page fault.
// ----------------------------------------------------------------------------
// A TLB hit steps through IDLE and LOOK, a miss also through MAP and OWN (map,
// then owner read), with a PAGE state before LOOK when PAGE_COUNT is not a power
// of two; LOOK and OWN wait while a response is still untaken. One item at a time.
// Reset clears the TLB, the FIFO pointer and the totals, then zeroes the page
// map entry by entry with req_tready low; a page counts as mapped only
// while its frame has been handed out and still names it as owner.
// ----------------------------------------------------------------------------
module tlb_page_table_translator
   import tlbpt_pkg::*;
#(
   parameter int TLB_ENTRIES  = TLB_ENTRIES_DEF,
   parameter int PAGE_COUNT   = PAGE_COUNT_DEF,
   parameter int FRAME_COUNT  = FRAME_COUNT_DEF,
   parameter int OFFSET_WIDTH = OFFSET_WIDTH_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   // request channel
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [ADDR_WIDTH-1:0]     req_tdata,  // virt_addr[15:0]
   // response channel
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output logic [RSP_DATA_WIDTH-1:0] rsp_tdata,  // phys_addr[14:0],
                                                 // hit_total[46:15],
                                                 // fault_total[78:47], zero
   output logic [RSP_USER_WIDTH-1:0] rsp_tuser   // tlb_hit[0], page_fault[1]
);

   localparam int PW  = $clog2(PAGE_COUNT);
   localparam int FW  = $clog2(FRAME_COUNT);
   localparam int RPW = (ADDR_WIDTH - OFFSET_WIDTH > 0) ? ADDR_WIDTH - OFFSET_WIDTH : 1;
   localparam bit PAGE_POW2 = (PAGE_COUNT & (PAGE_COUNT - 1)) == 0;

   typedef enum logic [2:0] {
      S_IDLE,
      S_PAGE,
      S_LOOK,
      S_MAP,
      S_OWN
   } state_type;

   state_type               state_ff, state_in;
   logic [ADDR_WIDTH-1:0]   addr_ff, addr_in;
   logic [PW-1:0]           page_ff, page_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [PHYS_WIDTH-1:0]   pa_ff, pa_in;
   logic                    hit_flag_ff, hit_flag_in;
   logic                    fault_flag_ff, fault_flag_in;
   logic [TOTAL_WIDTH-1:0]  hit_count_ff, hit_count_in;
   logic [TOTAL_WIDTH-1:0]  fault_count_ff, fault_count_in;
   logic [FW-1:0]           next_frame_ff, next_frame_in;
   logic                    wrapped_ff, wrapped_in;
   logic [PW-1:0]           clear_ptr_ff, clear_ptr_in;
   logic                    clear_busy_ff, clear_busy_in;

   logic                    req_accept;
   logic                    can_emit;
   logic                    fault_done;
   logic [31:0]             addr_shift;
   logic [RPW-1:0]          raw_page;
   logic [PW-1:0]           page_acc;
   logic [PW-1:0]           page_rem;
   logic [FW-1:0]           emit_frame;
   logic [PHYS_WIDTH+FW+OFFSET_WIDTH-1:0] pa_wide;
   logic                    mapped;

   // memories and their registered read data
   logic [FW-1:0]           page_map_mem [PAGE_COUNT];
   logic [PW-1:0]           owner_mem    [FRAME_COUNT];
   logic [FW-1:0]           map_rd_ff;
   logic [PW-1:0]           own_a_ff;
   logic [PW-1:0]           own_b_ff;
   logic                    map_we;
   logic                    own_we;

   // TLB interface
   tlb_ctl_type             tlb_ctl;
   logic                    tlb_hit;
   logic [FW-1:0]           tlb_frame;

   assign req_accept = req_tvalid && req_tready;
   assign req_tready = (state_ff == S_IDLE) && !clear_busy_ff;
   assign can_emit   = !rsp_valid_ff || rsp_tready;

   // split the page number off the logical address
   assign addr_shift = 32'(req_tdata) >> OFFSET_WIDTH;
   assign raw_page   = addr_shift[RPW-1:0];

   // wrap the page number into the page count
   generate
      if (PAGE_POW2) begin : g_mask
         logic [31:0] page_masked;
         assign page_masked = 32'(raw_page) & 32'(PAGE_COUNT - 1);
         assign page_acc    = page_masked[PW-1:0];
         assign page_rem    = page_ff;
      end else begin : g_recip
         localparam logic [RECIP_SHIFT:0] RECIP = (RECIP_SHIFT + 1)'((1 << RECIP_SHIFT) / PAGE_COUNT);
         logic [RPW+RECIP_SHIFT:0] prod;
         logic [RPW-1:0]           raw_ff;
         logic [RPW-1:0]           quot_ff;
         logic [RPW+12:0]          quot_scaled;
         logic [RPW+12:0]          rem_raw;
         logic [RPW+12:0]          rem_fix;

         // estimate the quotient by reciprocal, one low at most
         assign prod = (RPW + RECIP_SHIFT + 1)'(raw_page) * (RPW + RECIP_SHIFT + 1)'(RECIP);
         always_ff @(posedge clock) begin
            if (req_accept) begin
               raw_ff  <= raw_page;
               quot_ff <= prod[RPW+RECIP_SHIFT-1:RECIP_SHIFT];
            end
         end

         // remainder with one corrective subtract
         assign quot_scaled = (RPW + 13)'(quot_ff) * (RPW + 13)'(PAGE_COUNT);
         assign rem_raw     = (RPW + 13)'(raw_ff) - quot_scaled;
         assign rem_fix     = (32'(rem_raw) >= PAGE_COUNT) ?
                              rem_raw - (RPW + 13)'(PAGE_COUNT) : rem_raw;
         assign page_acc    = '0;
         assign page_rem    = rem_fix[PW-1:0];
      end
   endgenerate

   // advance the page map sweep after reset, one entry per cycle
   always_comb begin
      clear_ptr_in  = clear_ptr_ff;
      clear_busy_in = clear_busy_ff;
      if (clear_busy_ff) begin
         if (32'(clear_ptr_ff) == PAGE_COUNT - 1) begin
            clear_busy_in = 1'b0;
         end else begin
            clear_ptr_in = clear_ptr_ff + 1'b1;
         end
      end
   end

   // page map: frame per page, read every cycle at the current page
   always_ff @(posedge clock) begin
      if (clear_busy_ff) begin
         page_map_mem[clear_ptr_ff] <= '0;
      end else if (map_we) begin
         page_map_mem[page_ff] <= next_frame_ff;
      end
      map_rd_ff <= page_map_mem[page_ff];
   end

   // frame owners: port A checks the mapped frame, port B the FIFO victim
   always_ff @(posedge clock) begin
      if (own_we) begin
         owner_mem[next_frame_ff] <= page_ff;
      end
      own_a_ff <= owner_mem[map_rd_ff];
      own_b_ff <= owner_mem[next_frame_ff];
   end

   // a page is mapped when its frame has been handed out and still belongs to it
   assign mapped = (32'(map_rd_ff) < FRAME_COUNT) &&
                   (wrapped_ff || map_rd_ff < next_frame_ff) &&
                   (own_a_ff == page_ff);

   tlbpt_tlb #(
      .TLB_ENTRIES (TLB_ENTRIES),
      .PW          (PW),
      .FW          (FW)
   ) u_tlb (
      .clock       (clock),
      .reset       (reset),
      .lookup_page (page_ff),
      .ctl         (tlb_ctl),
      .fill_frame  (emit_frame),
      .evict_page  (own_b_ff),
      .hit         (tlb_hit),
      .hit_frame   (tlb_frame)
   );

   // sequence lookup, map read, owner check and writeback
   always_comb begin
      state_in       = state_ff;
      addr_in        = addr_ff;
      page_in        = page_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_tready;
      pa_in          = pa_ff;
      hit_flag_in    = hit_flag_ff;
      fault_flag_in  = fault_flag_ff;
      hit_count_in   = hit_count_ff;
      fault_count_in = fault_count_ff;
      next_frame_in  = next_frame_ff;
      wrapped_in     = wrapped_ff;
      tlb_ctl        = '0;
      map_we         = 1'b0;
      own_we         = 1'b0;
      emit_frame     = '0;
      fault_done     = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               addr_in  = req_tdata;
               page_in  = page_acc;
               state_in = PAGE_POW2 ? S_LOOK : S_PAGE;
            end
         end
         S_PAGE: begin
            page_in  = page_rem;
            state_in = S_LOOK;
         end
         S_LOOK: begin
            if (tlb_hit) begin
               emit_frame = tlb_frame;
               if (can_emit) begin
                  rsp_valid_in  = 1'b1;
                  hit_flag_in   = 1'b1;
                  fault_flag_in = 1'b0;
                  if (hit_count_ff != '1) begin
                     hit_count_in = hit_count_ff + 1'b1;
                  end
                  state_in = S_IDLE;
               end
            end else begin
               state_in = S_MAP;
            end
         end
         S_MAP: begin
            state_in = S_OWN;
         end
         S_OWN: begin
            emit_frame = mapped ? map_rd_ff : next_frame_ff;
            if (can_emit) begin
               tlb_ctl.fill  = 1'b1;
               rsp_valid_in  = 1'b1;
               hit_flag_in   = 1'b0;
               fault_flag_in = !mapped;
               if (!mapped) begin
                  fault_done    = 1'b1;
                  tlb_ctl.evict = wrapped_ff;
                  map_we        = 1'b1;
                  own_we        = 1'b1;
                  if (fault_count_ff != '1) begin
                     fault_count_in = fault_count_ff + 1'b1;
                  end
                  if (32'(next_frame_ff) == FRAME_COUNT - 1) begin
                     next_frame_in = '0;
                     wrapped_in    = 1'b1;
                  end else begin
                     next_frame_in = next_frame_ff + 1'b1;
                  end
               end
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
      pa_in = (rsp_valid_in && !(rsp_valid_ff && !rsp_tready)) ? pa_wide[PHYS_WIDTH-1:0] : pa_ff;
   end

   // form the physical address from frame and offset, drop the upper bits
   assign pa_wide = {{PHYS_WIDTH{1'b0}}, emit_frame, addr_ff[OFFSET_WIDTH-1:0]};

   // hold state, totals and the response register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         rsp_valid_ff   <= 1'b0;
         hit_count_ff   <= '0;
         fault_count_ff <= '0;
         next_frame_ff  <= '0;
         wrapped_ff     <= 1'b0;
         clear_ptr_ff   <= '0;
         clear_busy_ff  <= 1'b1;
      end else begin
         state_ff       <= state_in;
         rsp_valid_ff   <= rsp_valid_in;
         hit_count_ff   <= hit_count_in;
         fault_count_ff <= fault_count_in;
         next_frame_ff  <= next_frame_in;
         wrapped_ff     <= wrapped_in;
         clear_ptr_ff   <= clear_ptr_in;
         clear_busy_ff  <= clear_busy_in;
      end
      addr_ff       <= addr_in;
      page_ff       <= page_in;
      pa_ff         <= pa_in;
      hit_flag_ff   <= hit_flag_in;
      fault_flag_ff <= fault_flag_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, fault_count_ff, hit_count_ff, pa_ff};
   assign rsp_tuser  = {fault_flag_ff, hit_flag_ff};

   // a fault is never reported together with a TLB hit
   a_fault_not_hit: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[1] |-> !rsp_tuser[0])
      else $error("page fault flagged on a TLB hit");

   // the block is busy after taking a transfer
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (!reset && req_accept) |=> !req_tready)
      else $error("request accepted while an item is in progress");

   // every fault moves the FIFO frame pointer on
   a_frame_advance: assert property (@(posedge clock) disable iff (reset)
      (!reset && fault_done) |=> next_frame_ff != $past(next_frame_ff))
      else $error("frame pointer did not advance on a fault");

   // a response waiting to be taken keeps the totals steady
   a_totals_hold: assert property (@(posedge clock) disable iff (reset)
      (!reset && rsp_tvalid && !rsp_tready) |=> $stable(rsp_tdata))
      else $error("response changed while stalled");

endmodule

// ===== dv/tb_tlb_page_table_translator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_tlb_page_table_translator
// Self-checking bench for the TLB page table translator. Logical addresses
// are streamed in with random gaps and the responses are drained with random
// stalls. A local copy of the TLB, page map and frame owner table predicts
// each translation, both flags and both totals. Every response is checked
// field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_tlb_page_table_translator;
   import tlbpt_pkg::*;

   localparam int SLOTS      = TLB_ENTRIES_DEF;
   localparam int PAGES      = PAGE_COUNT_DEF;
   localparam int FRAMES     = FRAME_COUNT_DEF;
   localparam int OFFSET_W   = OFFSET_WIDTH_DEF;
   localparam int PAGE_W     = $clog2(PAGES);
   localparam int FRAME_W    = $clog2(FRAMES);
   localparam int SLOT_W     = $clog2(SLOTS);
   localparam int HALF_CYCLE = 4;
   localparam int REPORT_MAX = 10;

   typedef struct packed {
      logic [PHYS_WIDTH-1:0]  phys;
      logic                   hit;
      logic                   fault;
      logic [TOTAL_WIDTH-1:0] hit_total;
      logic [TOTAL_WIDTH-1:0] fault_total;
   } translation_type;

   logic                      clock      = 1'b0;
   logic                      reset      = 1'b1;
   logic                      req_tvalid = 1'b0;
   logic                      req_tready;
   logic [ADDR_WIDTH-1:0]     req_tdata  = '0;
   logic                      rsp_tvalid;
   logic                      rsp_tready = 1'b0;
   logic [RSP_DATA_WIDTH-1:0] rsp_tdata;
   logic [RSP_USER_WIDTH-1:0] rsp_tuser;

   // local copy of the translation state
   bit                     tlb_ok     [SLOTS];
   logic [PAGE_W-1:0]      tlb_vpage  [SLOTS];
   logic [FRAME_W-1:0]     tlb_pframe [SLOTS];
   logic [SLOT_W-1:0]      tlb_victim;
   bit                     map_ok     [PAGES];
   logic [FRAME_W-1:0]     map_frame  [PAGES];
   bit                     owner_ok   [FRAMES];
   logic [PAGE_W-1:0]      owner_page [FRAMES];
   logic [FRAME_W-1:0]     fifo_frame;
   logic [TOTAL_WIDTH-1:0] hits_so_far;
   logic [TOTAL_WIDTH-1:0] faults_so_far;

   translation_type predicted_q[$];
   int           mismatch_count  = 0;
   int           req_gap_max     = 10;
   int           rsp_stall_max   = 10;
   int           rsp_hold_cycles = 0;

   tlb_page_table_translator dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #(HALF_CYCLE) clock = ~clock;

   // walk the TLB, then the page map, and update state as the block should
   function automatic translation_type predict_translation(logic [ADDR_WIDTH-1:0] addr);
      translation_type     r;
      logic [PAGE_W-1:0]   page;
      logic [OFFSET_W-1:0] offset;
      logic [FRAME_W-1:0]  frame;
      logic [FRAME_W-1:0]  f;
      logic [PAGE_W-1:0]   old;
      bit                  hit;
      bit                  fault;
      int unsigned         wide;
      page   = PAGE_W'((addr >> OFFSET_W) % PAGES);
      offset = addr[OFFSET_W-1:0];
      frame  = '0;
      hit    = 1'b0;
      fault  = 1'b0;
      // lowest matching slot wins
      for (int i = 0; i < SLOTS; i++) begin
         if (!hit && tlb_ok[i] && tlb_vpage[i] == page) begin
            frame = tlb_pframe[i];
            hit   = 1'b1;
         end
      end
      if (hit) begin
         if (hits_so_far != '1) hits_so_far = hits_so_far + 1;
      end else begin
         if (!map_ok[page]) begin
            // take the next frame in FIFO order, unmap its previous owner
            f     = fifo_frame;
            fault = 1'b1;
            if (faults_so_far != '1) faults_so_far = faults_so_far + 1;
            if (owner_ok[f]) begin
               old         = owner_page[f];
               map_ok[old] = 1'b0;
               for (int i = 0; i < SLOTS; i++)
                  if (tlb_ok[i] && tlb_vpage[i] == old) tlb_ok[i] = 1'b0;
            end
            owner_ok[f]     = 1'b1;
            owner_page[f]   = page;
            map_ok[page]    = 1'b1;
            map_frame[page] = f;
            fifo_frame      = FRAME_W'((int'(f) + 1) % FRAMES);
         end
         frame = map_frame[page];
         // round-robin fill
         tlb_ok[tlb_victim]     = 1'b1;
         tlb_vpage[tlb_victim]  = page;
         tlb_pframe[tlb_victim] = frame;
         tlb_victim             = SLOT_W'((int'(tlb_victim) + 1) % SLOTS);
      end
      wide          = (int'(frame) << OFFSET_W) | int'(offset);
      r.phys        = wide[PHYS_WIDTH-1:0];
      r.hit         = hit;
      r.fault       = fault;
      r.hit_total   = hits_so_far;
      r.fault_total = faults_so_far;
      return r;
   endfunction

   function automatic void report_mismatch(string field, logic [TOTAL_WIDTH-1:0] want,
                                           logic [TOTAL_WIDTH-1:0] got);
      mismatch_count++;
      if (mismatch_count <= REPORT_MAX)
         $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $realtime, field, want, got);
   endfunction

   // offer one address after a random gap, predict it once transferred
   task automatic send_address(input logic [ADDR_WIDTH-1:0] addr);
      int gap;
      gap = $urandom_range(0, req_gap_max);
      @(negedge clock);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= addr;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predicted_q.push_back(predict_translation(addr));
   endtask

   // hold the request side idle until every predicted response is back
   task automatic wait_for_results();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (predicted_q.size() != 0) @(posedge clock);
   endtask

   // pick any page the local map holds as unmapped
   function automatic logic [PAGE_W-1:0] pick_unmapped_page();
      logic [PAGE_W-1:0] p;
      p = PAGE_W'($urandom_range(0, PAGES - 1));
      while (map_ok[p]) p = p + 1;
      return p;
   endfunction

   // extremes of the address, first faults and first hits
   task automatic test_directed_extremes();
      send_address(16'h0000);   // fault into frame 0
      send_address(16'h0000);   // hit
      send_address(16'hFFFF);   // top page, top offset
      send_address(16'hFF00);
      send_address(16'h00FF);
      send_address(16'h5555);
      send_address(16'hAAAA);
      send_address(16'h7F80);
      send_address(16'h8001);
      send_address(16'hAA55);
   endtask

   // overflow the TLB so an early page misses while still mapped
   task automatic test_tlb_capacity();
      for (int i = 0; i < SLOTS; i++)
         send_address({8'(8'h10 + i), 8'($urandom)});
      send_address({8'h00, 8'h3C});
      send_address({8'hFF, 8'hC3});
   endtask

   // wrap the frame FIFO, then check a cached page loses its TLB entry
   task automatic test_frame_reuse();
      logic [PAGE_W-1:0] victim;
      while (!owner_ok[fifo_frame])
         send_address({pick_unmapped_page(), 8'($urandom)});
      victim = owner_page[fifo_frame];
      send_address({victim, 8'($urandom)});   // victim now sits in the TLB
      send_address({pick_unmapped_page(), 8'($urandom)});
      send_address({victim, 8'($urandom)});   // must fault, not hit stale
      send_address({victim, 8'($urandom)});
      wait_for_results();
   endtask

   // stall the response side for a long stretch while requests keep coming
   task automatic test_back_pressure();
      req_gap_max     = 0;
      rsp_hold_cycles = 200;
      for (int i = 0; i < 16; i++)
         send_address(16'($urandom));
      wait_for_results();
      req_gap_max = 10;
   endtask

   // working sets for hits, a wider page range for faults and reuse, and noise
   task automatic test_random_traffic(input int count);
      logic [PAGE_W-1:0] ws_base;
      int                ws_size;
      int                pick;
      logic [PAGE_W-1:0] page;
      ws_base = '0;
      ws_size = 4;
      for (int n = 0; n < count; n++) begin
         if (n % 100 == 0) begin
            ws_base = PAGE_W'($urandom);
            ws_size = $urandom_range(2, 24);
            if ($urandom_range(0, 3) == 0) begin
               req_gap_max   = 0;
               rsp_stall_max = 0;
            end else begin
               req_gap_max   = 10;
               rsp_stall_max = 10;
            end
         end
         if (n % 300 == 299) wait_for_results();
         pick = $urandom_range(0, 99);
         if (pick < 60)
            page = ws_base + PAGE_W'($urandom_range(0, ws_size - 1));
         else if (pick < 85)
            page = PAGE_W'($urandom_range(0, 159));
         else
            page = PAGE_W'($urandom);
         send_address({page, 8'($urandom)});
      end
      req_gap_max   = 10;
      rsp_stall_max = 10;
   endtask

   // response side: random stalls, then check each transfer
   initial begin
      translation_type want;
      int              stall;
      while (reset) @(posedge clock);
      forever begin
         if (rsp_hold_cycles > 0) begin
            stall           = rsp_hold_cycles;
            rsp_hold_cycles = 0;
         end else begin
            stall = $urandom_range(0, rsp_stall_max);
         end
         @(negedge clock);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
         if (predicted_q.size() == 0) begin
            report_mismatch("unexpected response, phys_addr", '0,
                            rsp_tdata[PHYS_WIDTH-1:0]);
         end else begin
            want = predicted_q.pop_front();
            if (rsp_tdata[14:0] != want.phys)
               report_mismatch("phys_addr", want.phys, rsp_tdata[14:0]);
            if (rsp_tuser[0] != want.hit)
               report_mismatch("tlb_hit", want.hit, rsp_tuser[0]);
            if (rsp_tuser[1] != want.fault)
               report_mismatch("page_fault", want.fault, rsp_tuser[1]);
            if (rsp_tdata[46:15] != want.hit_total)
               report_mismatch("hit_total", want.hit_total, rsp_tdata[46:15]);
            if (rsp_tdata[78:47] != want.fault_total)
               report_mismatch("fault_total", want.fault_total, rsp_tdata[78:47]);
         end
      end
   end

   // reset, run the tests, drain and report
   initial begin
      for (int i = 0; i < SLOTS; i++) begin
         tlb_ok[i]     = 1'b0;
         tlb_vpage[i]  = '0;
         tlb_pframe[i] = '0;
      end
      for (int i = 0; i < PAGES; i++) begin
         map_ok[i]    = 1'b0;
         map_frame[i] = '0;
      end
      for (int i = 0; i < FRAMES; i++) begin
         owner_ok[i]   = 1'b0;
         owner_page[i] = '0;
      end
      tlb_victim    = '0;
      fifo_frame    = '0;
      hits_so_far   = '0;
      faults_so_far = '0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed_extremes();
      test_tlb_capacity();
      wait_for_results();
      test_frame_reuse();
      test_back_pressure();
      test_random_traffic(1200);

      wait_for_results();
      repeat (40) @(posedge clock);
      if (mismatch_count == 0 && predicted_q.size() == 0) begin
         $display("** tlb_page_table_translator: PASSED **");
      end else begin
         $display("** tlb_page_table_translator: FAILED **");
      end
      $finish;
   end

   // hang guard
   initial begin
      #5_000_000;
      $display("** tlb_page_table_translator: FAILED **");
      $finish;
   end

endmodule

// ===== files.f =====
design/tlbpt_pkg.sv
design/tlbpt_tlb.sv
design/tlb_page_table_translator.sv
dv/tb_tlb_page_table_translator.sv
